// ===== src/imtp_pkg.sv =====
// Shared types and character codes for the IPv4 mask text parser.
`timescale 1ns / 1ps

package imtp_pkg;

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam int unsigned NUM_OCTETS = 4;
   localparam int unsigned OCTET_W    = 8;
   localparam int unsigned COUNT_W    = 3;
   localparam int unsigned PREFIX_W   = 6;
   localparam int unsigned ADDR_W     = 32;

   // Prefix digits saturate here, one above the longest legal prefix
   localparam logic [PREFIX_W-1:0] PREFIX_SAT = 6'd33;
   localparam logic [COUNT_W-1:0]  COUNT_ONE  = 3'd1;
   localparam logic [COUNT_W-1:0]  COUNT_MAX  = 3'd4;

   typedef enum logic [1:0] {
      PH_ADDR,
      PH_PREFIX,
      PH_STAR,
      PH_ERROR
   } phase_type;

   typedef struct packed {
      phase_type                                phase;
      logic [COUNT_W-1:0]                       octet_count;
      logic [NUM_OCTETS-1:0][OCTET_W-1:0]       octets;
      logic [PREFIX_W-1:0]                      prefix_accum;
      logic                                     last_was_dot;
   } scan_state_type;

   typedef struct packed {
      logic                 is_ipv4;
      logic [ADDR_W-1:0]    address;
      logic [PREFIX_W-1:0]  prefix_len;
   } result_type;

endpackage

// ===== src/imtp_scan.sv =====
// Character scanner: holds the parse state and advances it one character per transfer.
`timescale 1ns / 1ps

module imtp_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              ch,
   output imtp_pkg::scan_state_type state
);

   imtp_pkg::phase_type                                          phase_ff, phase_in;
   logic [imtp_pkg::COUNT_W-1:0]                                 count_ff, count_in;
   logic [imtp_pkg::NUM_OCTETS-1:0][imtp_pkg::OCTET_W-1:0]       octets_ff, octets_in;
   logic [imtp_pkg::PREFIX_W-1:0]                                accum_ff, accum_in;
   logic                                                         dot_ff, dot_in;

   logic                           is_digit;
   logic                           is_end;
   logic [3:0]                     digit;
   logic [1:0]                     octet_idx;
   logic [imtp_pkg::COUNT_W-1:0]   count_dec;
   logic [8:0]                     accum_wide;

   assign is_digit   = ch inside {[imtp_pkg::CH_ZERO:imtp_pkg::CH_NINE]};
   assign is_end     = (ch == imtp_pkg::CH_NUL);
   assign digit      = 4'(ch - imtp_pkg::CH_ZERO);
   assign count_dec  = count_ff - imtp_pkg::COUNT_ONE;
   assign octet_idx  = count_dec[1:0];
   // accum * 10 + digit, accum never above 33
   assign accum_wide = {accum_ff, 3'b000} + {2'b00, accum_ff, 1'b0} + {5'b0, digit};

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (is_end) begin
            phase_in = imtp_pkg::PH_ADDR;
         end else begin
            case (phase_ff)
               imtp_pkg::PH_ADDR: begin
                  if (is_digit) begin
                     phase_in = imtp_pkg::PH_ADDR;
                  end else if (ch == imtp_pkg::CH_DOT) begin
                     phase_in = (count_ff >= imtp_pkg::COUNT_MAX) ? imtp_pkg::PH_ERROR
                                                                  : imtp_pkg::PH_ADDR;
                  end else if (ch == imtp_pkg::CH_STAR) begin
                     phase_in = dot_ff ? imtp_pkg::PH_STAR : imtp_pkg::PH_ERROR;
                  end else if (ch == imtp_pkg::CH_SLASH) begin
                     phase_in = imtp_pkg::PH_PREFIX;
                  end else begin
                     phase_in = imtp_pkg::PH_ERROR;
                  end
               end
               imtp_pkg::PH_PREFIX: begin
                  phase_in = is_digit ? imtp_pkg::PH_PREFIX : imtp_pkg::PH_ERROR;
               end
               default: begin
                  phase_in = imtp_pkg::PH_ERROR;
               end
            endcase
         end
      end
   end

   // Datapath next values
   always_comb begin
      count_in  = count_ff;
      octets_in = octets_ff;
      accum_in  = accum_ff;
      dot_in    = dot_ff;
      if (step) begin
         if (is_end) begin
            count_in  = imtp_pkg::COUNT_ONE;
            octets_in = '0;
            accum_in  = '0;
            dot_in    = 1'b0;
         end else if (phase_ff == imtp_pkg::PH_ADDR) begin
            if (is_digit) begin
               // Accumulate the current octet modulo 256
               for (int i = 0; i < imtp_pkg::NUM_OCTETS; i++) begin
                  if (octet_idx == 2'(i)) begin
                     octets_in[i] = {octets_ff[i][4:0], 3'b000} + {octets_ff[i][6:0], 1'b0}
                                    + {4'b0000, digit};
                  end
               end
               dot_in = 1'b0;
            end else if (ch == imtp_pkg::CH_DOT) begin
               if (count_ff < imtp_pkg::COUNT_MAX) begin
                  count_in = count_ff + imtp_pkg::COUNT_ONE;
                  dot_in   = 1'b1;
               end
            end else if (ch == imtp_pkg::CH_STAR) begin
               dot_in = 1'b0;
            end else if (ch == imtp_pkg::CH_SLASH) begin
               accum_in = '0;
               dot_in   = 1'b0;
            end
         end else if (phase_ff == imtp_pkg::PH_PREFIX && is_digit) begin
            // Saturate so any long digit string stays too long
            accum_in = (accum_wide > {3'b000, imtp_pkg::PREFIX_SAT}) ? imtp_pkg::PREFIX_SAT
                                                                    : accum_wide[5:0];
         end
      end
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= imtp_pkg::PH_ADDR;
         count_ff  <= imtp_pkg::COUNT_ONE;
         octets_ff <= '0;
         accum_ff  <= '0;
         dot_ff    <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         octets_ff <= octets_in;
         accum_ff  <= accum_in;
         dot_ff    <= dot_in;
      end
   end

   // Drive state view
   always_comb begin
      state.phase        = phase_ff;
      state.octet_count  = count_ff;
      state.octets       = octets_ff;
      state.prefix_accum = accum_ff;
      state.last_was_dot = dot_ff;
   end

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff >= imtp_pkg::COUNT_ONE && count_ff <= imtp_pkg::COUNT_MAX)
      else $error("octet count out of range");

   a_accum_sat: assert property (@(posedge clock) disable iff (reset)
      accum_ff <= imtp_pkg::PREFIX_SAT)
      else $error("prefix accumulator above saturation");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      step && is_end |=> phase_ff == imtp_pkg::PH_ADDR && count_ff == imtp_pkg::COUNT_ONE
                         && octets_ff == '0 && !dot_ff)
      else $error("terminator did not clear parse state");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == imtp_pkg::PH_ERROR && !(step && is_end) |=> phase_ff == imtp_pkg::PH_ERROR)
      else $error("error phase left before terminator");

   a_star_after_dot: assert property (@(posedge clock) disable iff (reset)
      phase_ff == imtp_pkg::PH_STAR |-> count_ff > imtp_pkg::COUNT_ONE)
      else $error("wildcard phase with a single octet");
`endif

endmodule

// ===== src/imtp_finish.sv =====
// Result formation: prefix length selection and address masking from the parse state.
`timescale 1ns / 1ps

module imtp_finish (
   input  imtp_pkg::scan_state_type state,
   output imtp_pkg::result_type     result
);

   logic [imtp_pkg::PREFIX_W-1:0] full_bits;
   logic [imtp_pkg::PREFIX_W-1:0] star_bits;
   logic [imtp_pkg::PREFIX_W-1:0] bits;
   logic [imtp_pkg::PREFIX_W-1:0] final_bits;
   logic [imtp_pkg::COUNT_W-1:0]  count_dec;
   logic                          ok;
   logic [imtp_pkg::ADDR_W-1:0]   mask;
   logic [imtp_pkg::ADDR_W-1:0]   addr;

   // Octets times eight; the count never exceeds four, so this is at most 32
   assign full_bits = {state.octet_count, 3'b000};
   assign count_dec = state.octet_count - imtp_pkg::COUNT_ONE;
   assign star_bits = {count_dec, 3'b000};

   // First octet lands in the top byte
   assign addr = {state.octets[0], state.octets[1], state.octets[2], state.octets[3]};

   // Pick the prefix from the ending phase
   always_comb begin
      ok   = 1'b1;
      bits = '0;
      case (state.phase)
         imtp_pkg::PH_ERROR: begin
            ok = 1'b0;
         end
         imtp_pkg::PH_STAR: begin
            bits = star_bits;
         end
         imtp_pkg::PH_PREFIX: begin
            if (state.prefix_accum > full_bits) begin
               ok = 1'b0;
            end else begin
               bits = state.prefix_accum;
            end
         end
         default: begin
            bits = '0;
         end
      endcase
   end

   // Default an empty or zero prefix to the octets given
   assign final_bits = (bits == '0) ? full_bits : bits;
   assign mask       = ~({imtp_pkg::ADDR_W{1'b1}} >> final_bits);

   always_comb begin
      if (ok) begin
         result.is_ipv4    = 1'b1;
         result.address    = addr & mask;
         result.prefix_len = final_bits;
      end else begin
         result.is_ipv4    = 1'b0;
         result.address    = '0;
         result.prefix_len = '0;
      end
   end

endmodule

// ===== src/ipv4_mask_text_parser.sv =====
// Top level of the IPv4 mask text parser: input register, scanner, result register.
`timescale 1ns / 1ps

// Takes mask text such as "10.1.2.0/24" or "192.168.*" one byte per transfer and
// gives one result for each zero byte: an IPv4 flag, the address with the bits past
// the prefix cleared, and the prefix length. Bytes are taken every cycle unless the
// input stalls; each byte is registered on input before it is applied to the parse
// state, so the rate is one byte per clock while the input does not stall. A zero
// byte that is applied loads its result into the result register, which drives
// rsp_valid. The result register frees the input side: bytes keep flowing while a
// result waits, and only a zero byte meeting a full, stalled result register stalls
// the input. After each zero byte the parser is back in its reset state.
module ipv4_mask_text_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_ch,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_is_ipv4,
   output logic [imtp_pkg::ADDR_W-1:0]       rsp_address,
   output logic [imtp_pkg::PREFIX_W-1:0]     rsp_prefix_len
);

   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               ch_ff, ch_in;
   logic                     out_valid_ff, out_valid_in;
   imtp_pkg::result_type     result_ff, result_in;

   logic                     is_end;
   logic                     advance;
   logic                     emit;
   logic                     accept;
   imtp_pkg::scan_state_type state;
   imtp_pkg::result_type     result;

   // Advance the held byte unless it is a terminator facing a blocked result slot
   assign is_end    = (ch_ff == imtp_pkg::CH_NUL);
   assign advance   = in_valid_ff && (!is_end || !out_valid_ff || !rsp_stall);
   assign emit      = advance && is_end;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   imtp_scan u_scan (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .ch    (ch_ff),
      .state (state)
   );

   imtp_finish u_finish (
      .state  (state),
      .result (result)
   );

   // Input register next values
   always_comb begin
      in_valid_in = in_valid_ff;
      ch_in       = ch_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         ch_in       = req_ch;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register next values
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      result_in    = result_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         result_in    = result;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ch_ff     <= ch_in;
      result_ff <= result_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_is_ipv4    = result_ff.is_ipv4;
   assign rsp_address    = result_ff.address;
   assign rsp_prefix_len = result_ff.prefix_len;

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |-> !emit)
      else $error("result overwritten while stalled");

   a_stall_only_on_end: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && is_end && out_valid_ff)
      else $error("input stalled without a blocked terminator");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      emit |=> out_valid_ff)
      else $error("emitted result not presented");
`endif

endmodule

// ===== tb/tb_ipv4_mask_text_parser.sv =====
// Self-checking testbench for the IPv4 mask text parser: directed masks, random masks and backpressure.
`timescale 1ns / 1ps

module tb_ipv4_mask_text_parser;

   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned HOLDOFF_LEN  = 300;
   localparam int unsigned MAX_REPORTS  = 10;
   localparam int unsigned SETTLE_TICKS = 10;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [7:0]                    req_ch = imtp_pkg::CH_NUL;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_is_ipv4;
   logic [imtp_pkg::ADDR_W-1:0]   rsp_address;
   logic [imtp_pkg::PREFIX_W-1:0] rsp_prefix_len;

   // Shadow parse state
   imtp_pkg::phase_type           scan_phase;
   logic [imtp_pkg::COUNT_W-1:0]  octet_cnt;
   logic [imtp_pkg::OCTET_W-1:0]  octet_val [imtp_pkg::NUM_OCTETS];
   logic [imtp_pkg::PREFIX_W-1:0] prefix_digits;
   logic                          after_dot;

   imtp_pkg::result_type          results_due [$];
   logic [7:0]                    mask_text [$];

   int unsigned         send_idle_pct = 0;
   int unsigned         rsp_stall_pct = 0;
   int unsigned         hold_request = 0;
   int unsigned         hold_left = 0;
   int unsigned         chars_sent = 0;
   int unsigned         mismatches = 0;
   int unsigned         idle_cycles = 0;

   ipv4_mask_text_parser dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_ch         (req_ch),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_is_ipv4    (rsp_is_ipv4),
      .rsp_address    (rsp_address),
      .rsp_prefix_len (rsp_prefix_len)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Return the shadow parser to its idle state
   function automatic void clear_mask_scan();
      scan_phase    = imtp_pkg::PH_ADDR;
      octet_cnt     = imtp_pkg::COUNT_ONE;
      foreach (octet_val[i]) octet_val[i] = '0;
      prefix_digits = '0;
      after_dot     = 1'b0;
   endfunction

   initial clear_mask_scan();

   // Work out the result that a zero byte produces from the current parse state
   function automatic imtp_pkg::result_type mask_result();
      imtp_pkg::result_type        r;
      int unsigned                 bits;
      logic [imtp_pkg::ADDR_W-1:0] addr;
      r    = '0;
      bits = 0;
      case (scan_phase)
         imtp_pkg::PH_ERROR: return r;
         imtp_pkg::PH_STAR: bits = (int'(octet_cnt) - 1) * imtp_pkg::OCTET_W;
         imtp_pkg::PH_PREFIX: begin
            if (int'(prefix_digits) > int'(octet_cnt) * imtp_pkg::OCTET_W) return r;
            bits = prefix_digits;
         end
         default: ;
      endcase
      // missing or zero prefix defaults to the octet count
      if (bits == 0)
         bits = (octet_cnt < imtp_pkg::COUNT_MAX) ? int'(octet_cnt) * imtp_pkg::OCTET_W
                                                  : imtp_pkg::ADDR_W;
      addr         = {octet_val[0], octet_val[1], octet_val[2], octet_val[3]};
      r.is_ipv4    = 1'b1;
      r.address    = addr & ({imtp_pkg::ADDR_W{1'b1}} << (imtp_pkg::ADDR_W - bits));
      r.prefix_len = imtp_pkg::PREFIX_W'(bits);
      return r;
   endfunction

   // Advance the shadow parser by one byte; a zero byte queues a result
   function automatic void apply_mask_char(logic [7:0] c);
      logic        is_digit;
      int unsigned digit_val;
      int unsigned acc;
      int unsigned idx;
      is_digit  = (c >= imtp_pkg::CH_ZERO) && (c <= imtp_pkg::CH_NINE);
      digit_val = int'(c) - int'(imtp_pkg::CH_ZERO);
      if (c == imtp_pkg::CH_NUL) begin
         results_due.push_back(mask_result());
         clear_mask_scan();
         return;
      end
      case (scan_phase)
         imtp_pkg::PH_ADDR: begin
            if (is_digit) begin
               idx = (int'(octet_cnt) - 1) & 3;
               octet_val[idx] = imtp_pkg::OCTET_W'(octet_val[idx] * 10 + digit_val);
               after_dot = 1'b0;
            end else if (c == imtp_pkg::CH_DOT) begin
               if (octet_cnt >= imtp_pkg::COUNT_MAX) begin
                  scan_phase = imtp_pkg::PH_ERROR;
               end else begin
                  octet_cnt = octet_cnt + 1'b1;
                  after_dot = 1'b1;
               end
            end else if (c == imtp_pkg::CH_STAR) begin
               scan_phase = after_dot ? imtp_pkg::PH_STAR : imtp_pkg::PH_ERROR;
               after_dot  = 1'b0;
            end else if (c == imtp_pkg::CH_SLASH) begin
               scan_phase    = imtp_pkg::PH_PREFIX;
               prefix_digits = '0;
               after_dot     = 1'b0;
            end else begin
               scan_phase = imtp_pkg::PH_ERROR;
            end
         end
         imtp_pkg::PH_PREFIX: begin
            if (is_digit) begin
               acc = prefix_digits * 10 + digit_val;
               prefix_digits = (acc > imtp_pkg::PREFIX_SAT) ? imtp_pkg::PREFIX_SAT
                                                            : imtp_pkg::PREFIX_W'(acc);
            end else begin
               scan_phase = imtp_pkg::PH_ERROR;
            end
         end
         default: scan_phase = imtp_pkg::PH_ERROR;
      endcase
   endfunction

   function automatic void note_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
   endfunction

   // Track accepted bytes and check each accepted result against the oldest prediction
   always @(posedge clock) begin
      imtp_pkg::result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) apply_mask_char(req_ch);
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               note_mismatch($sformatf("unexpected result ipv4=%0b addr=%h len=%0d",
                                       rsp_is_ipv4, rsp_address, rsp_prefix_len));
            end else begin
               want = results_due.pop_front();
               if (rsp_is_ipv4 !== want.is_ipv4)
                  note_mismatch($sformatf("is_ipv4 expected %0b got %0b",
                                          want.is_ipv4, rsp_is_ipv4));
               if (rsp_address !== want.address)
                  note_mismatch($sformatf("address expected %h got %h",
                                          want.address, rsp_address));
               if (rsp_prefix_len !== want.prefix_len)
                  note_mismatch($sformatf("prefix_len expected %0d got %0d",
                                          want.prefix_len, rsp_prefix_len));
            end
         end
      end
   end

   // Drive result stall: a requested hold-off first, random stalls otherwise
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // End the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Offer one byte after a random gap and hold it until the transfer
   task automatic send_char(logic [7:0] c);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      do @(posedge clock); while (req_stall);
      chars_sent++;
   endtask

   function automatic void add_char(logic [7:0] c);
      mask_text.push_back(c);
   endfunction

   function automatic void add_text(string t);
      for (int i = 0; i < t.len(); i++) add_char(t[i]);
   endfunction

   function automatic void add_number(int unsigned v);
      add_text($sformatf("%0d", v));
   endfunction

   function automatic void add_digits(int unsigned n);
      repeat (n) add_char(imtp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
   endfunction

   function automatic logic [7:0] noise_char();
      case ($urandom_range(0, 5))
         0: return imtp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
         1: return imtp_pkg::CH_DOT;
         2: return imtp_pkg::CH_STAR;
         3: return imtp_pkg::CH_SLASH;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   // Send the buffered text followed by its terminating zero byte
   task automatic send_mask();
      foreach (mask_text[i]) send_char(mask_text[i]);
      send_char(imtp_pkg::CH_NUL);
      mask_text.delete();
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
   endtask

   // Mostly well-formed masks with random content, some broken or pure noise
   task automatic send_random_mask();
      int unsigned n_oct;
      if ($urandom_range(0, 99) < 12) begin
         repeat ($urandom_range(0, 8)) add_char(noise_char());
      end else begin
         n_oct = ($urandom_range(0, 19) == 0) ? 5 : $urandom_range(1, 4);
         for (int k = 0; k < n_oct; k++) begin
            if (k > 0) add_char(imtp_pkg::CH_DOT);
            case ($urandom_range(0, 9))
               0: ;
               1: add_digits($urandom_range(4, 7));
               2: add_number($urandom_range(256, 999));
               default: add_number($urandom_range(0, 255));
            endcase
         end
         case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4: begin
               add_char(imtp_pkg::CH_DOT);
               add_char(imtp_pkg::CH_STAR);
            end
            default: begin
               add_char(imtp_pkg::CH_SLASH);
               case ($urandom_range(0, 9))
                  0: ;
                  1: add_digits($urandom_range(3, 5));
                  2: begin
                     add_char(imtp_pkg::CH_ZERO);
                     add_number($urandom_range(0, 32));
                  end
                  default: add_number($urandom_range(0, n_oct * imtp_pkg::OCTET_W + 3));
               endcase
            end
         endcase
         // break the tail now and then
         if ($urandom_range(0, 9) == 0) add_char(noise_char());
      end
      send_mask();
   endtask

   // Boundary bytes and each special case of the grammar
   task automatic test_directed_masks();
      send_mask();                         // empty string
      add_char(8'hFF);        send_mask(); // bad character, top byte value
      add_text("*");          send_mask(); // star without a dot
      add_text("9.*");        send_mask(); // wildcard
      add_text("1/999");      send_mask(); // prefix too long, saturating
      add_text("1.2./0");     send_mask(); // empty octet, zero prefix
      add_text("....");       send_mask(); // fifth octet
      add_text("/ ");         send_mask(); // space in prefix
      add_text("300.2.3.9/20"); send_mask(); // octet modulo 256, prefix clears bits
   endtask

   task automatic test_random_masks(int unsigned n_chars);
      int unsigned stop_at;
      stop_at = chars_sent + n_chars;
      while (chars_sent < stop_at) send_random_mask();
   endtask

   // Hold the result side off while short masks keep arriving
   task automatic test_output_holdoff();
      hold_request = HOLDOFF_LEN;
      repeat (40) begin
         add_number($urandom_range(0, 255));
         send_mask();
      end
   endtask

   // Pause the sender until every result has come back, several times
   task automatic test_drain_pause();
      repeat (5) begin
         repeat (3) send_random_mask();
         wait_drain();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed_masks();

      test_random_masks(320);
      send_idle_pct = 84;
      test_random_masks(320);
      send_idle_pct = 0;
      rsp_stall_pct = 84;
      test_random_masks(320);
      send_idle_pct = 35;
      rsp_stall_pct = 35;
      test_random_masks(320);

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      test_output_holdoff();

      send_idle_pct = 35;
      rsp_stall_pct = 35;
      test_drain_pause();

      wait_drain();
      repeat (SETTLE_TICKS) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
